// File: rtl/tbve_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Tricubic Bezier volume evaluator package
// Shared types and constants for the evaluator modules.
// ---------------------------------------------------------------------------
package tbve_pkg;

    localparam int unsigned CP_COUNT   = 64;
    localparam int unsigned CP_AW      = 6;
    localparam int unsigned STEPS_W    = 11;
    localparam int unsigned IDX_W      = 10;
    localparam logic [10:0] STEPS_MIN  = 11'd2;
    localparam logic [10:0] STEPS_MAX  = 11'd1024;
    localparam logic        KIND_WRITE = 1'b0;
    localparam logic        KIND_EVAL  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_BERN,
        ST_ACC,
        ST_FIN
    } state_t;

endpackage

// File: rtl/tbve_div.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Parameter divider
// Restoring divider: one quotient bit per cycle, computes
// t = (i * 2^F + floor(d/2)) / d for one axis.
// ---------------------------------------------------------------------------
module tbve_div #(
    parameter int unsigned FRAC_WIDTH = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      go,
    input  logic [9:0]                idx,
    input  logic [9:0]                den,
    output logic                      done,
    output logic [FRAC_WIDTH:0]       quo
);
    localparam int unsigned NW = FRAC_WIDTH + 11;
    localparam int unsigned CW = $clog2(NW + 1);

    logic [NW-1:0] num_reg, num_next;
    logic [10:0]   rem_reg, rem_next;
    logic [9:0]    den_reg, den_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [11:0]   trial;

    always_comb
    begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, num_reg[NW-1]} - {2'b0, den_reg};
        if (go)
        begin
            num_next  = ({{(NW-10){1'b0}}, (idx > den ? den : idx)} << FRAC_WIDTH)
                        + {{(NW-10){1'b0}}, den >> 1};
            rem_next  = '0;
            den_next  = den;
            cnt_next  = CW'(NW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[11])
            begin
                rem_next = trial[10:0];
                num_next = {num_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[9:0], num_reg[NW-1]};
                num_next = {num_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = num_reg[FRAC_WIDTH:0];
endmodule

// File: rtl/tbve_mem.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Control point store
// 64 x (3 coordinates) synchronous memory, one write and one read port,
// registered read data.
// ---------------------------------------------------------------------------
module tbve_mem #(
    parameter int unsigned DW = 96
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [tbve_pkg::CP_AW-1:0] waddr,
    input  logic [DW-1:0]              wdata,
    input  logic [tbve_pkg::CP_AW-1:0] raddr,
    output logic [DW-1:0]              rdata
);
    logic [DW-1:0] mem [tbve_pkg::CP_COUNT];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// File: rtl/tricubic_bezier_volume_eval_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Tricubic Bezier volume evaluator
// Holds 4x4x4 control points and evaluates the volume at grid positions.
// ---------------------------------------------------------------------------
// Usage: an item is transferred when start is high and busy is low. kind 0
// writes one control point (cp_u/v/w, coord_x/y/z) in that cycle; busy stays
// low, so the next item can follow at the very next edge. kind 1 evaluates at
// (grid_u, grid_v, grid_w) and returns one result on point_x/y/z, marked by
// done for one cycle.
// An evaluation runs three bit-serial parameter divisions, then the Bernstein
// weights, then the accumulation (one memory read per control point plus the
// read and weight pipeline), then rounding and saturation. busy is already
// low while the result is rounded, so the next item can be transferred before
// done is high. The divider and the single memory read port bound the
// evaluation time.
// grid_steps is written over the cfg channel (cfg_valid/cfg_ready, cfg_data)
// while the block is idle and start is low; it resets to 2.
// After reset the block clears all 64 entries of the control point store;
// busy is high during that pass. The receiver cannot stall; each result is
// shown for exactly one cycle.
// ---------------------------------------------------------------------------
module tricubic_bezier_volume_eval_top #(
    parameter int unsigned COORD_WIDTH = 32,
    parameter int unsigned FRAC_WIDTH  = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic                    kind,
    input  logic [1:0]              cp_u,
    input  logic [1:0]              cp_v,
    input  logic [1:0]              cp_w,
    input  logic signed [COORD_WIDTH-1:0] coord_x,
    input  logic signed [COORD_WIDTH-1:0] coord_y,
    input  logic signed [COORD_WIDTH-1:0] coord_z,
    input  logic [9:0]              grid_u,
    input  logic [9:0]              grid_v,
    input  logic [9:0]              grid_w,
    output logic                    done,
    output logic signed [COORD_WIDTH-1:0] point_x,
    output logic signed [COORD_WIDTH-1:0] point_y,
    output logic signed [COORD_WIDTH-1:0] point_z,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [10:0]             cfg_data
);
    localparam int unsigned CW  = COORD_WIDTH;
    localparam int unsigned F   = FRAC_WIDTH;
    localparam int unsigned TW  = F + 1;
    localparam int unsigned PW  = 2 * TW + 2;
    localparam int unsigned AW  = CW + TW + 7;
    localparam logic [PW-1:0] HALF = PW'(1) << (F - 1);

    tbve_pkg::state_t state_reg, state_next;
    logic [10:0] steps_reg;
    logic [6:0]  clr_reg;
    logic        clearing;
    logic [9:0]  den;
    logic [9:0]  gv_reg, gw_reg;
    logic [1:0]  axis_reg, axis_next;
    logic        div_go;
    logic        div_done;
    logic [TW-1:0] div_q;
    logic [TW-1:0] t_reg [3];
    // Bernstein weights per axis.
    logic [TW-1:0] b_reg [3][4];
    logic [3:0]  bstep_reg, bstep_next;
    logic [TW-1:0] tq, sq, t2q, s2q;
    logic [TW-1:0] t2_reg, s2_reg;
    logic [PW-1:0] mprod;
    logic [6:0]  acc_cnt_reg;
    logic [5:0]  rd_addr_reg;
    logic [TW-1:0] wuv_reg, w_reg;
    logic [PW-1:0] wuv_p;
    logic [5:0]  cur_addr;
    logic signed [AW-1:0] acc_reg [3];
    logic [3*CW-1:0] rdata;
    logic        mem_we;
    logic [5:0]  mem_waddr;
    logic [3*CW-1:0] mem_wdata;
    logic        fin_reg;
    logic signed [CW-1:0] out_reg [3];
    logic        done_reg;
    logic signed [CW-1:0] pdata_reg [3];

    function automatic logic signed [CW-1:0] sat(input logic signed [AW-1:0] s);
        logic signed [AW-1:0] r;
        r = (s + $signed(AW'(HALF))) >>> F;
        if (r > $signed(AW'({1'b0, {(CW-1){1'b1}}})))
            sat = {1'b0, {(CW-1){1'b1}}};
        else if (r < -$signed(AW'({1'b1, {(CW-1){1'b0}}})) )
            sat = {1'b1, {(CW-1){1'b0}}};
        else
            sat = r[CW-1:0];
    endfunction

    assign clearing  = (clr_reg != 7'd64);
    assign den       = (steps_reg < tbve_pkg::STEPS_MIN) ? 10'd1 :
                       (steps_reg > tbve_pkg::STEPS_MAX) ? 10'd1023 :
                       10'(steps_reg - 11'd1);
    assign busy      = clearing || (state_reg != tbve_pkg::ST_IDLE);
    // Holding cfg_ready low while start is high keeps a configuration write
    // from landing in the same cycle as an item transfer.
    assign cfg_ready = !busy && !start;

    // Shared multiplier for the Bernstein sequence.
    assign tq  = t_reg[axis_reg];
    assign sq  = TW'((TW)'(1) << F) - tq;
    always_comb
    begin
        case (bstep_reg)
            4'd0:    mprod = PW'(tq) * PW'(tq);
            4'd1:    mprod = PW'(sq) * PW'(sq);
            4'd2:    mprod = PW'(s2_reg) * PW'(sq);
            4'd3:    mprod = PW'(3) * PW'(tq) * PW'(s2_reg);
            4'd4:    mprod = PW'(3) * PW'(t2_reg) * PW'(sq);
            default: mprod = PW'(t2_reg) * PW'(tq);
        endcase
    end
    assign t2q = TW'((mprod + HALF) >> F);
    assign s2q = t2q;

    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        bstep_next = bstep_reg;
        div_go     = 1'b0;
        case (state_reg)
            tbve_pkg::ST_IDLE:
            begin
                if (start && !busy && kind == tbve_pkg::KIND_EVAL)
                begin
                    state_next = tbve_pkg::ST_DIV;
                    axis_next  = 2'd0;
                    div_go     = 1'b1;
                end
            end
            tbve_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    if (axis_reg == 2'd2)
                    begin
                        state_next = tbve_pkg::ST_BERN;
                        axis_next  = 2'd0;
                        bstep_next = 4'd0;
                    end
                    else
                    begin
                        axis_next = axis_reg + 2'd1;
                        div_go    = 1'b1;
                    end
                end
            end
            tbve_pkg::ST_BERN:
            begin
                if (bstep_reg == 4'd5)
                begin
                    bstep_next = 4'd0;
                    if (axis_reg == 2'd2)
                        state_next = tbve_pkg::ST_ACC;
                    else
                        axis_next = axis_reg + 2'd1;
                end
                else
                    bstep_next = bstep_reg + 4'd1;
            end
            tbve_pkg::ST_ACC:
            begin
                if (acc_cnt_reg == 7'd67)
                    state_next = tbve_pkg::ST_FIN;
            end
            tbve_pkg::ST_FIN:
                state_next = tbve_pkg::ST_IDLE;
            default:
                state_next = tbve_pkg::ST_IDLE;
        endcase
    end

    tbve_div #(.FRAC_WIDTH(F)) u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .go   (div_go),
        .idx  (state_reg == tbve_pkg::ST_IDLE ? grid_u :
               (axis_reg == 2'd0 ? gv_reg : gw_reg)),
        .den  (den),
        .done (div_done),
        .quo  (div_q)
    );

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = {cp_u, cp_v, cp_w};
        mem_wdata = {coord_z, coord_y, coord_x};
        if (clearing)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_reg[5:0];
            mem_wdata = '0;
        end
        else if (start && !busy && kind == tbve_pkg::KIND_WRITE)
            mem_we = 1'b1;
    end

    assign cur_addr = acc_cnt_reg[5:0];

    tbve_mem #(.DW(3 * CW)) u_mem (
        .clk  (clk),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .raddr(cur_addr),
        .rdata(rdata)
    );

    // Weight pipeline: wuv at count c, w registered alongside the read data.
    assign wuv_p = PW'(b_reg[0][cur_addr[5:4]]) * PW'(b_reg[1][cur_addr[3:2]]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= tbve_pkg::ST_IDLE;
            steps_reg    <= 11'd2;
            clr_reg      <= '0;
            axis_reg     <= '0;
            bstep_reg    <= '0;
            acc_cnt_reg  <= '0;
            fin_reg      <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
            bstep_reg <= bstep_next;
            if (clearing)
                clr_reg <= clr_reg + 7'd1;
            if (cfg_valid && cfg_ready)
                steps_reg <= cfg_data;
            if (state_reg == tbve_pkg::ST_ACC)
                acc_cnt_reg <= acc_cnt_reg + 7'd1;
            else
                acc_cnt_reg <= '0;
            fin_reg      <= (state_reg == tbve_pkg::ST_FIN);
            done_reg     <= fin_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            gv_reg <= grid_v;
            gw_reg <= grid_w;
        end
        if (div_done)
            t_reg[axis_reg] <= div_q;
        if (state_reg == tbve_pkg::ST_BERN)
        begin
            case (bstep_reg)
                4'd0:    t2_reg <= t2q;
                4'd1:    s2_reg <= s2q;
                4'd2:    b_reg[axis_reg][0] <= t2q;
                4'd3:    b_reg[axis_reg][1] <= t2q;
                4'd4:    b_reg[axis_reg][2] <= t2q;
                default: b_reg[axis_reg][3] <= t2q;
            endcase
        end
        wuv_reg     <= TW'((wuv_p + HALF) >> F);
        rd_addr_reg <= cur_addr;
        w_reg       <= TW'((PW'(wuv_reg) * PW'(b_reg[2][rd_addr_reg[1:0]]) + HALF) >> F);
        if (state_reg == tbve_pkg::ST_IDLE)
        begin
            for (int c = 0; c < 3; c++)
                acc_reg[c] <= '0;
        end
        else if (state_reg == tbve_pkg::ST_ACC && acc_cnt_reg >= 7'd3
                 && acc_cnt_reg <= 7'd66)
        begin
            for (int c = 0; c < 3; c++)
                acc_reg[c] <= acc_reg[c] + AW'($signed(pdata_reg[c]) * $signed({1'b0, w_reg}));
        end
        if (fin_reg)
        begin
            for (int c = 0; c < 3; c++)
                out_reg[c] <= sat(acc_reg[c]);
        end
    end

    // Read data registered once more to line up with the weight.
    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 3; c++)
            pdata_reg[c] <= rdata[c*CW +: CW];
    end

    assign done    = done_reg;
    assign point_x = out_reg[0];
    assign point_y = out_reg[1];
    assign point_z = out_reg[2];

`ifndef ASSERT_OFF
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");
    a_busy_on_eval: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && kind == tbve_pkg::KIND_EVAL) |=> busy)
        else $error("busy not raised after an evaluate transfer");
    a_no_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !cfg_ready)
        else $error("configuration accepted while busy");
`endif
endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Tricubic Bezier volume evaluator testbench
// Fills the control-point lattice and evaluates the volume over several grid
// step settings. An in-bench predictor computes every evaluated point and a
// monitor compares each done strobe against the oldest predicted point.
// ---------------------------------------------------------------------------
module tb_top;

    localparam int LIMIT = 3000000;
    localparam int F     = 16;

    typedef struct {
        logic              kind;
        logic [1:0]        cu, cv, cw;
        logic signed [31:0] x, y, z;
        logic [9:0]        gu, gv, gw;
    } volume_op_t;

    typedef struct {
        logic signed [31:0] x, y, z;
    } point_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic kind = tbve_pkg::KIND_WRITE;
    logic [1:0] cp_u = '0, cp_v = '0, cp_w = '0;
    logic signed [31:0] coord_x = '0, coord_y = '0, coord_z = '0;
    logic [9:0] grid_u = '0, grid_v = '0, grid_w = '0;
    logic done;
    logic signed [31:0] point_x, point_y, point_z;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [10:0] cfg_data = '0;

    volume_op_t pending_ops[$];
    point_t     expected_points[$];
    volume_op_t held_op;
    logic signed [31:0] lattice[3][64];
    logic [10:0] steps_reg;
    bit quiet = 1'b0;
    int errors = 0, cycles = 0, n_writes = 0, n_evals = 0, n_points = 0, n_cfg = 0;

    tricubic_bezier_volume_eval_top u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .kind(kind),
        .cp_u(cp_u), .cp_v(cp_v), .cp_w(cp_w),
        .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
        .grid_u(grid_u), .grid_v(grid_v), .grid_w(grid_w),
        .done(done), .point_x(point_x), .point_y(point_y), .point_z(point_z),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always #6 clk = ~clk;

    function automatic logic [63:0] round_frac(logic [63:0] v);
        return (v + 64'd32768) >> F;
    endfunction

    function automatic void bernstein_weights(input logic [9:0] idx, input logic [63:0] den,
                                              output logic [63:0] b[4]);
        logic [63:0] i, t, s, t2, s2;
        i  = (idx > den) ? den : idx;
        t  = ((i << F) + den / 2) / den;
        s  = 64'd65536 - t;
        t2 = round_frac(t * t);
        s2 = round_frac(s * s);
        b[0] = round_frac(s2 * s);
        b[1] = round_frac(64'd3 * t * s2);
        b[2] = round_frac(64'd3 * t2 * s);
        b[3] = round_frac(t2 * t);
    endfunction

    function automatic point_t eval_volume(volume_op_t op);
        logic [63:0] den, wuv, w;
        logic [63:0] bu[4], bv[4], bw[4];
        logic signed [127:0] acc[3];
        logic signed [31:0] r[3];
        point_t p;
        den = (steps_reg < tbve_pkg::STEPS_MIN) ? 64'd1 :
              (steps_reg > tbve_pkg::STEPS_MAX) ? 64'd1023 : 64'(steps_reg) - 64'd1;
        bernstein_weights(op.gu, den, bu);
        bernstein_weights(op.gv, den, bv);
        bernstein_weights(op.gw, den, bw);
        for (int c = 0; c < 3; c++) acc[c] = '0;
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++) begin
                wuv = round_frac(bu[i] * bv[j]);
                for (int k = 0; k < 4; k++) begin
                    w = round_frac(wuv * bw[k]);
                    for (int c = 0; c < 3; c++)
                        acc[c] += 128'(lattice[c][i*16 + j*4 + k]) * $signed({64'd0, w});
                end
            end
        for (int c = 0; c < 3; c++) begin
            acc[c] = (acc[c] + 128'sd32768) >>> F;
            if (acc[c] > 128'sd2147483647) r[c] = 32'h7fffffff;
            else if (acc[c] < -128'sd2147483648) r[c] = 32'h80000000;
            else r[c] = acc[c][31:0];
        end
        p.x = r[0]; p.y = r[1]; p.z = r[2];
        return p;
    endfunction

    task automatic apply_op(volume_op_t op);
        if (op.kind == tbve_pkg::KIND_WRITE) begin
            lattice[0][{op.cu, op.cv, op.cw}] = op.x;
            lattice[1][{op.cu, op.cv, op.cw}] = op.y;
            lattice[2][{op.cu, op.cv, op.cw}] = op.z;
            n_writes++;
        end else begin
            expected_points.push_back(eval_volume(op));
            n_evals++;
        end
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h, expected %h (cycle %0d)", what, got, want, cycles);
        errors++;
    endtask

    // Driver: an item transfers at an edge where start is high and busy low.
    always @(posedge clk) begin
        if (rst_n) begin
            if (start && !busy) apply_op(held_op);
            if (!start || !busy) begin
                if (pending_ops.size() > 0 && (quiet || $urandom_range(99) >= 7)) begin
                    held_op = pending_ops.pop_front();
                    start   <= 1'b1;
                    kind    <= held_op.kind;
                    cp_u <= held_op.cu; cp_v <= held_op.cv; cp_w <= held_op.cw;
                    coord_x <= held_op.x; coord_y <= held_op.y; coord_z <= held_op.z;
                    grid_u <= held_op.gu; grid_v <= held_op.gv; grid_w <= held_op.gw;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: results cannot be held off, so each done cycle is one transfer.
    always @(posedge clk) begin
        point_t want;
        cycles++;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_top: FAIL");
            $finish;
        end
        if (rst_n && done) begin
            if (expected_points.size() == 0) begin
                report_mismatch("unexpected result x", point_x, 32'h0);
            end else begin
                want = expected_points.pop_front();
                n_points++;
                if (point_x !== want.x) report_mismatch("point_x", point_x, want.x);
                if (point_y !== want.y) report_mismatch("point_y", point_y, want.y);
                if (point_z !== want.z) report_mismatch("point_z", point_z, want.z);
            end
        end
    end

    function automatic volume_op_t make_write(logic [5:0] a, logic signed [31:0] x,
                                              logic signed [31:0] y, logic signed [31:0] z);
        volume_op_t op;
        op.kind = tbve_pkg::KIND_WRITE;
        {op.cu, op.cv, op.cw} = a;
        op.x = x; op.y = y; op.z = z;
        op.gu = 10'($urandom); op.gv = 10'($urandom); op.gw = 10'($urandom);
        return op;
    endfunction

    function automatic volume_op_t make_eval(logic [9:0] u, logic [9:0] v, logic [9:0] w);
        volume_op_t op;
        op.kind = tbve_pkg::KIND_EVAL;
        {op.cu, op.cv, op.cw} = 6'($urandom);
        op.x = $urandom; op.y = $urandom; op.z = $urandom;
        op.gu = u; op.gv = v; op.gw = w;
        return op;
    endfunction

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $signed(32'($urandom_range(131071))) - 32'sd65536;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [9:0] rand_index(logic [10:0] st);
        int hi;
        hi = (st < tbve_pkg::STEPS_MIN) ? 1 : (st > tbve_pkg::STEPS_MAX) ? 1023 : st - 1;
        if ($urandom_range(9) == 0) return 10'($urandom);
        return 10'($urandom_range(hi));
    endfunction

    task automatic drain();
        while (pending_ops.size() > 0 || start || expected_points.size() > 0)
            @(posedge clk);
        // A trailing write leaves no result behind; allow an evaluation's latency.
        repeat (200) @(posedge clk);
    endtask

    task automatic write_steps(logic [10:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        steps_reg = v;
        n_cfg++;
    endtask

    initial begin
        logic [10:0] step_list[10];
        step_list = '{11'd2, 11'd1024, 11'd0, 11'd1, 11'd2047,
                      11'd3, 11'd17, 11'd100, 11'd1000, 11'd513};
        for (int c = 0; c < 3; c++)
            for (int a = 0; a < 64; a++) lattice[c][a] = '0;
        steps_reg = tbve_pkg::STEPS_MIN;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: evaluate the cleared store, then corner and extreme points.
        pending_ops.push_back(make_eval(10'd0, 10'd0, 10'd0));
        pending_ops.push_back(make_eval(10'd1, 10'd1023, 10'd1));
        for (int a = 0; a < 64; a += 21)
            pending_ops.push_back(make_write(6'(a), 32'h7fffffff, 32'h80000000, 32'sd65536));
        pending_ops.push_back(make_write(6'd63, 32'h7fffffff, 32'h7fffffff, -32'sd1));
        pending_ops.push_back(make_eval(10'd0, 10'd0, 10'd0));
        pending_ops.push_back(make_eval(10'd1, 10'd1, 10'd1));
        pending_ops.push_back(make_eval(10'd1023, 10'd1023, 10'd1023));
        drain();
        write_steps(11'd1024);
        for (int a = 0; a < 64; a++)
            pending_ops.push_back(make_write(6'(a), 32'h7fffffff, 32'h7fffffff, 32'h80000000));
        pending_ops.push_back(make_eval(10'd0, 10'd511, 10'd1023));
        pending_ops.push_back(make_eval(10'd512, 10'd512, 10'd512));
        pending_ops.push_back(make_eval(10'd1023, 10'd0, 10'd300));
        drain();

        // Random phases, one grid step setting each, extremes among them.
        for (int ph = 0; ph < 10; ph++) begin
            write_steps(step_list[ph]);
            quiet = (ph == 4);
            for (int n = 0; n < 180; n++) begin
                if ($urandom_range(99) < 45)
                    pending_ops.push_back(make_write(6'($urandom), rand_coord(),
                                                     rand_coord(), rand_coord()));
                else
                    pending_ops.push_back(make_eval(rand_index(steps_reg),
                                                    rand_index(steps_reg),
                                                    rand_index(steps_reg)));
            end
            drain();
        end
        quiet = 1'b0;

        $display("covered %0d grid step writes, %0d point writes, %0d evaluations",
                 n_cfg, n_writes, n_evals);
        $display("checked %0d evaluated points, %0d mismatches", n_points, errors);
        if (errors == 0 && expected_points.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end
endmodule
